FILE: hdl/ptfe_pkg.sv
package ptfe_pkg;

   // geometry
   localparam int COORD_BITS   = 12;
   localparam int MAX_VERTICES = 1024;
   localparam int CNT_BITS     = $clog2(MAX_VERTICES);
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int SQ_BITS      = 2 * COORD_BITS;
   localparam int NORM_BITS    = 2 * COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * NORM_BITS;

   // field widths
   localparam int FIELD_BITS = 12;
   localparam int TAG_BITS   = 8;
   localparam int SEG_BITS   = 10;
   localparam int LEN_BITS   = 16;
   localparam int COS_BITS   = 7;

   // length: sqrt(400 * n) gives twice the length in tenths
   localparam int                LEN_SCALE_BITS = 9;
   localparam logic [8:0]        LEN_SCALE      = 9'd400;
   localparam int                RAD_BITS       = NORM_BITS + LEN_SCALE_BITS;
   localparam logic [LEN_BITS-1:0] LEN_MAX      = '1;

   // cosine: floor(4e8 * d^2 / (n1 * n2)) then a root
   localparam int          SCALE_BITS = 29;
   localparam logic [28:0] COS_SCALE  = 29'd400000000;
   localparam int          QUOT_BITS  = 29;
   localparam int          NUM_BITS   = PROD_BITS + SCALE_BITS;
   localparam int          DIV_CNT_BITS = $clog2(QUOT_BITS + 1);
   localparam int          HALF_BITS  = NORM_BITS;

   // shared root unit, even width
   localparam int SQRT_BITS = (RAD_BITS > QUOT_BITS + 1) ? RAD_BITS : QUOT_BITS + 1;
   localparam int ROOT_BITS = SQRT_BITS / 2;

   // rounding of the 1/10000 value to hundredths, x/100 as (x*5243)>>19
   localparam int           QH_BITS     = 14;
   localparam logic [13:0]  Q_HALF      = 14'd50;
   localparam int           RECIP_BITS  = 13;
   localparam logic [12:0]  RECIP_100   = 13'd5243;
   localparam int           RECIP_SHIFT = 19;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
      logic signed [DIFF_BITS-1:0] ldx;
      logic signed [DIFF_BITS-1:0] ldy;
      logic                        emit;
      logic [SEG_BITS-1:0]         seg;
      logic [TAG_BITS-1:0]         tag;
   } ptfe_job_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM,
      BK_PROD,
      BK_SCALE,
      BK_LEN,
      BK_DIV,
      BK_ROOT,
      BK_ROUND,
      BK_OUT
   } ptfe_back_state_type;

endpackage

FILE: hdl/ptfe_if.sv
interface ptfe_req_if;
   logic                                valid;
   logic                                ready;
   logic [ptfe_pkg::FIELD_BITS-1:0]     vertex_x;
   logic [ptfe_pkg::FIELD_BITS-1:0]     vertex_y;
   logic                                start_contour;

   modport source (output valid, vertex_x, vertex_y, start_contour, input ready);
   modport sink   (input valid, vertex_x, vertex_y, start_contour, output ready);
endinterface

interface ptfe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ptfe_pkg::COS_BITS-1:0]    turn_cosine;
   logic [ptfe_pkg::LEN_BITS-1:0]    earlier_length;
   logic [ptfe_pkg::LEN_BITS-1:0]    later_length;
   logic [ptfe_pkg::TAG_BITS-1:0]    tag_out;
   logic [ptfe_pkg::SEG_BITS-1:0]    segment_number;
   logic                             degenerate;

   modport source (output valid, turn_cosine, earlier_length, later_length, tag_out,
                   segment_number, degenerate, input ready);
   modport sink   (input valid, turn_cosine, earlier_length, later_length, tag_out,
                   segment_number, degenerate, output ready);
endinterface

interface ptfe_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ptfe_pkg::TAG_BITS-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/ptfe_sqrt.sv
module ptfe_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ptfe_pkg::SQRT_BITS-1:0]  operand,
   output logic                            done,
   output logic [ptfe_pkg::ROOT_BITS-1:0]  root
);

   logic [ptfe_pkg::SQRT_BITS-1:0] v_ff, v_in;
   logic [ptfe_pkg::SQRT_BITS-1:0] r_ff, r_in;
   logic [ptfe_pkg::SQRT_BITS-1:0] bit_ff, bit_in;
   logic                           done_ff, done_in;
   logic [ptfe_pkg::SQRT_BITS-1:0] trial;

   // one result bit per cycle, digit pair method
   always_comb begin
      trial   = r_ff + bit_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (start) begin
         v_in   = operand;
         r_in   = '0;
         bit_in = ptfe_pkg::SQRT_BITS'(1) << (ptfe_pkg::SQRT_BITS - 2);
      end else if (bit_ff != '0) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = bit_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[ptfe_pkg::ROOT_BITS-1:0];

endmodule

FILE: hdl/ptfe_div.sv
module ptfe_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ptfe_pkg::NUM_BITS-1:0]   num,
   input  logic [ptfe_pkg::PROD_BITS-1:0]  den,
   output logic                            done,
   output logic [ptfe_pkg::QUOT_BITS-1:0]  quot
);

   logic [ptfe_pkg::PROD_BITS-1:0]    rem_ff, rem_in;
   logic [ptfe_pkg::QUOT_BITS-1:0]    low_ff, low_in;
   logic [ptfe_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              done_ff, done_in;
   logic [ptfe_pkg::PROD_BITS:0]      shifted;
   logic [ptfe_pkg::PROD_BITS:0]      diff;
   logic                              fits;

   // restoring division, one quotient bit per cycle; quotient bits enter low_ff
   always_comb begin
      shifted = {rem_ff, low_ff[ptfe_pkg::QUOT_BITS-1]};
      diff    = shifted - {1'b0, den};
      fits    = shifted >= {1'b0, den};
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num[ptfe_pkg::NUM_BITS-1:ptfe_pkg::QUOT_BITS];
         low_in = num[ptfe_pkg::QUOT_BITS-1:0];
         cnt_in = ptfe_pkg::DIV_CNT_BITS'(ptfe_pkg::QUOT_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[ptfe_pkg::PROD_BITS-1:0] : shifted[ptfe_pkg::PROD_BITS-1:0];
         low_in  = {low_ff[ptfe_pkg::QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - ptfe_pkg::DIV_CNT_BITS'(1);
         done_in = (cnt_ff == ptfe_pkg::DIV_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = low_ff;

endmodule

FILE: hdl/ptfe_queue.sv
module ptfe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptfe_pkg::ptfe_job_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output ptfe_pkg::ptfe_job_type pop_data
);

   ptfe_pkg::ptfe_job_type slot_ff [2];
   logic                   wr_ff, wr_in;
   logic                   rd_ff, rd_in;
   logic [1:0]             cnt_ff, cnt_in;

   // two-entry ring between front and back
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign full      = cnt_ff[1];
   assign pop_valid = cnt_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ff];

endmodule

FILE: hdl/ptfe_front.sv
module ptfe_front (
   input  logic                            clock,
   input  logic                            reset,
   ptfe_req_if.sink                        req_port,
   input  logic [ptfe_pkg::TAG_BITS-1:0]   tag,
   input  logic                            queue_full,
   output logic                            push,
   output ptfe_pkg::ptfe_job_type          push_data
);

   logic [ptfe_pkg::COORD_BITS-1:0]        last_x_ff, last_y_ff;
   logic signed [ptfe_pkg::DIFF_BITS-1:0]  last_dx_ff, last_dy_ff;
   logic [ptfe_pkg::CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [ptfe_pkg::CNT_BITS-1:0]          cnt_eff;
   logic [ptfe_pkg::CNT_BITS-1:0]          seg_full;
   logic [ptfe_pkg::COORD_BITS-1:0]        x, y;
   logic signed [ptfe_pkg::DIFF_BITS-1:0]  dx, dy;
   logic                                   accept, has_seg;

   // classify the vertex and form the segment
   always_comb begin
      accept   = req_port.valid && !queue_full;
      x        = req_port.vertex_x[ptfe_pkg::COORD_BITS-1:0];
      y        = req_port.vertex_y[ptfe_pkg::COORD_BITS-1:0];
      cnt_eff  = req_port.start_contour ? '0 : cnt_ff;
      has_seg  = cnt_eff != '0;
      dx       = $signed({1'b0, x}) - $signed({1'b0, last_x_ff});
      dy       = $signed({1'b0, y}) - $signed({1'b0, last_y_ff});
      seg_full = cnt_eff - ptfe_pkg::CNT_BITS'(1);
      cnt_in   = (cnt_eff < ptfe_pkg::CNT_BITS'(ptfe_pkg::MAX_VERTICES - 1))
               ? cnt_eff + ptfe_pkg::CNT_BITS'(1) : cnt_eff;

      push           = accept && has_seg;
      push_data.dx   = dx;
      push_data.dy   = dy;
      push_data.ldx  = last_dx_ff;
      push_data.ldy  = last_dy_ff;
      push_data.emit = cnt_eff >= ptfe_pkg::CNT_BITS'(2);
      push_data.seg  = ptfe_pkg::SEG_BITS'(seg_full);
      push_data.tag  = tag;
   end

   // previous vertex and segment
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         last_dx_ff <= '0;
         last_dy_ff <= '0;
         cnt_ff     <= '0;
      end else if (accept) begin
         last_x_ff <= x;
         last_y_ff <= y;
         cnt_ff    <= cnt_in;
         if (has_seg) begin
            last_dx_ff <= dx;
            last_dy_ff <= dy;
         end
      end
   end

   assign req_port.ready = !queue_full;

endmodule

FILE: hdl/ptfe_back.sv
module ptfe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  ptfe_pkg::ptfe_job_type job_data,
   output logic                   pop,
   ptfe_rsp_if.source             rsp_port
);

   localparam int MW = 2 * ptfe_pkg::DIFF_BITS;

   ptfe_pkg::ptfe_back_state_type  state_ff, state_in;
   ptfe_pkg::ptfe_job_type         job_ff;

   logic signed [MW-1:0]                 px_ff, py_ff, sx1_ff, sy1_ff, sx2_ff, sy2_ff;
   logic [ptfe_pkg::NORM_BITS-1:0]       d_ff, n1_ff, n2_ff;
   logic                                 degen_ff;
   logic [ptfe_pkg::PROD_BITS-1:0]       prod_ff, d2_ff;
   logic [ptfe_pkg::RAD_BITS-1:0]        rad_ff;
   logic [ptfe_pkg::HALF_BITS+ptfe_pkg::SCALE_BITS-1:0] hi_ff, lo_ff;
   logic [ptfe_pkg::LEN_BITS-1:0]        len_ff, last_len_ff, earlier_ff;
   logic [ptfe_pkg::QH_BITS-1:0]         q_ff;
   logic [ptfe_pkg::COS_BITS-1:0]        cos_ff;

   logic                                 rsp_valid_ff;
   logic [ptfe_pkg::COS_BITS-1:0]        rsp_cos_ff;
   logic [ptfe_pkg::LEN_BITS-1:0]        rsp_early_ff, rsp_late_ff;
   logic [ptfe_pkg::TAG_BITS-1:0]        rsp_tag_ff;
   logic [ptfe_pkg::SEG_BITS-1:0]        rsp_seg_ff;
   logic                                 rsp_degen_ff;

   logic                                 sq_start, sq_done;
   logic [ptfe_pkg::SQRT_BITS-1:0]       sq_operand;
   logic [ptfe_pkg::ROOT_BITS-1:0]       sq_root;
   logic                                 div_start, div_done;
   logic [ptfe_pkg::NUM_BITS-1:0]        div_num;
   logic [ptfe_pkg::QUOT_BITS-1:0]       div_quot;

   logic signed [MW:0]                   dot_w, dot_abs;
   logic [ptfe_pkg::ROOT_BITS:0]         half_w;
   logic [ptfe_pkg::LEN_BITS-1:0]        len_calc;
   logic [ptfe_pkg::QH_BITS-1:0]         q_calc;
   logic [ptfe_pkg::QH_BITS-1:0]         q_sum;
   logic [ptfe_pkg::QH_BITS+ptfe_pkg::RECIP_BITS-1:0] cos_w;
   logic                                 out_free;

   ptfe_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .done    (sq_done),
      .root    (sq_root)
   );

   ptfe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (prod_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // datapath helpers
   always_comb begin
      dot_w   = {px_ff[MW-1], px_ff} + {py_ff[MW-1], py_ff};
      dot_abs = dot_w[MW] ? -dot_w : dot_w;
      div_num = (ptfe_pkg::NUM_BITS'(hi_ff) << ptfe_pkg::HALF_BITS) + ptfe_pkg::NUM_BITS'(lo_ff);
      half_w  = ({1'b0, sq_root} + (ptfe_pkg::ROOT_BITS + 1)'(1)) >> 1;
      if (half_w > (ptfe_pkg::ROOT_BITS + 1)'(ptfe_pkg::LEN_MAX)) begin
         len_calc = ptfe_pkg::LEN_MAX;
      end else begin
         len_calc = ptfe_pkg::LEN_BITS'(half_w);
      end
      q_calc   = ptfe_pkg::QH_BITS'(half_w);
      q_sum    = q_ff + ptfe_pkg::Q_HALF;
      cos_w    = q_sum * ptfe_pkg::RECIP_100;
      out_free = !rsp_valid_ff || rsp_port.ready;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      pop        = 1'b0;
      sq_start   = 1'b0;
      sq_operand = ptfe_pkg::SQRT_BITS'(rad_ff);
      div_start  = 1'b0;
      case (state_ff)
         ptfe_pkg::BK_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               state_in = ptfe_pkg::BK_MUL;
            end
         end
         ptfe_pkg::BK_MUL:  state_in = ptfe_pkg::BK_SUM;
         ptfe_pkg::BK_SUM:  state_in = ptfe_pkg::BK_PROD;
         ptfe_pkg::BK_PROD: state_in = ptfe_pkg::BK_SCALE;
         ptfe_pkg::BK_SCALE: begin
            sq_start = 1'b1;
            state_in = ptfe_pkg::BK_LEN;
         end
         ptfe_pkg::BK_LEN: begin
            if (sq_done) begin
               if (!job_ff.emit) begin
                  state_in = ptfe_pkg::BK_IDLE;
               end else if (degen_ff) begin
                  state_in = ptfe_pkg::BK_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ptfe_pkg::BK_DIV;
               end
            end
         end
         ptfe_pkg::BK_DIV: begin
            if (div_done) begin
               sq_start   = 1'b1;
               sq_operand = ptfe_pkg::SQRT_BITS'(div_quot);
               state_in   = ptfe_pkg::BK_ROOT;
            end
         end
         ptfe_pkg::BK_ROOT: begin
            if (sq_done) begin
               state_in = ptfe_pkg::BK_ROUND;
            end
         end
         ptfe_pkg::BK_ROUND: state_in = ptfe_pkg::BK_OUT;
         ptfe_pkg::BK_OUT: begin
            if (out_free) begin
               state_in = ptfe_pkg::BK_IDLE;
            end
         end
         default: state_in = ptfe_pkg::BK_IDLE;
      endcase
   end

   // state register and last segment length
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptfe_pkg::BK_IDLE;
         last_len_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ptfe_pkg::BK_LEN && sq_done) begin
            last_len_ff <= len_calc;
         end
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= job_data;
      end
      if (state_ff == ptfe_pkg::BK_MUL) begin
         px_ff  <= job_ff.ldx * job_ff.dx;
         py_ff  <= job_ff.ldy * job_ff.dy;
         sx1_ff <= job_ff.ldx * job_ff.ldx;
         sy1_ff <= job_ff.ldy * job_ff.ldy;
         sx2_ff <= job_ff.dx * job_ff.dx;
         sy2_ff <= job_ff.dy * job_ff.dy;
      end
      if (state_ff == ptfe_pkg::BK_SUM) begin
         d_ff  <= ptfe_pkg::NORM_BITS'(dot_abs);
         n1_ff <= {1'b0, sx1_ff[ptfe_pkg::SQ_BITS-1:0]} + {1'b0, sy1_ff[ptfe_pkg::SQ_BITS-1:0]};
         n2_ff <= {1'b0, sx2_ff[ptfe_pkg::SQ_BITS-1:0]} + {1'b0, sy2_ff[ptfe_pkg::SQ_BITS-1:0]};
      end
      if (state_ff == ptfe_pkg::BK_PROD) begin
         prod_ff  <= n1_ff * n2_ff;
         d2_ff    <= d_ff * d_ff;
         rad_ff   <= n2_ff * ptfe_pkg::LEN_SCALE;
         degen_ff <= (n1_ff == '0) || (n2_ff == '0);
      end
      if (state_ff == ptfe_pkg::BK_SCALE) begin
         hi_ff <= d2_ff[ptfe_pkg::PROD_BITS-1:ptfe_pkg::HALF_BITS] * ptfe_pkg::COS_SCALE;
         lo_ff <= d2_ff[ptfe_pkg::HALF_BITS-1:0] * ptfe_pkg::COS_SCALE;
      end
      if (state_ff == ptfe_pkg::BK_LEN && sq_done) begin
         len_ff     <= len_calc;
         earlier_ff <= last_len_ff;
         cos_ff     <= '0;
      end
      if (state_ff == ptfe_pkg::BK_ROOT && sq_done) begin
         q_ff <= q_calc;
      end
      if (state_ff == ptfe_pkg::BK_ROUND) begin
         cos_ff <= ptfe_pkg::COS_BITS'(cos_w >> ptfe_pkg::RECIP_SHIFT);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ptfe_pkg::BK_OUT && out_free) begin
         rsp_cos_ff   <= cos_ff;
         rsp_early_ff <= earlier_ff;
         rsp_late_ff  <= len_ff;
         rsp_tag_ff   <= job_ff.tag;
         rsp_seg_ff   <= job_ff.seg;
         rsp_degen_ff <= degen_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ptfe_pkg::BK_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.turn_cosine    = rsp_cos_ff;
   assign rsp_port.earlier_length = rsp_early_ff;
   assign rsp_port.later_length   = rsp_late_ff;
   assign rsp_port.tag_out        = rsp_tag_ff;
   assign rsp_port.segment_number = rsp_seg_ff;
   assign rsp_port.degenerate     = rsp_degen_ff;

endmodule

FILE: hdl/polyline_turn_feature_extractor_core.sv
// Polyline turn feature extractor. Vertices come in one request at a time; a request
// with start_contour set opens a new contour. From the third vertex of a contour on,
// each vertex yields one response: the absolute cosine of the turn in hundredths, the
// lengths of both segments in tenths of a pixel, the contour tag and the number of the
// later segment; a zero-length segment gives cosine 0 with degenerate set. The first
// vertex of a contour only updates the front; every later one is a job for the back
// end, which takes one job at a time, paced by the shared bit-serial square root unit
// (for the length, then the cosine) and the restoring divider. A two-entry queue lets
// the front accept up to two vertices ahead of the back end, and the response register
// lets work continue while a result waits. Write the tag only while idle.
module polyline_turn_feature_extractor_core (
   input  logic        clock,
   input  logic        reset,
   ptfe_req_if.sink    req_port,
   ptfe_rsp_if.source  rsp_port,
   ptfe_csr_if.sink    csr_port
);

   logic [ptfe_pkg::TAG_BITS-1:0] tag_ff;
   logic                          q_push, q_full, q_pop, q_valid;
   ptfe_pkg::ptfe_job_type        q_in, q_out;

   // contour tag register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (csr_port.valid) begin
         tag_ff <= csr_port.data;
      end
   end

   assign csr_port.ready = 1'b1;

   ptfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .tag        (tag_ff),
      .queue_full (q_full),
      .push       (q_push),
      .push_data  (q_in)
   );

   ptfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out)
   );

   ptfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_data  (q_out),
      .pop       (q_pop),
      .rsp_port  (rsp_port)
   );

endmodule
